### sv/wprm_pkg.sv
package wprm_pkg;

  localparam int COUNT_W    = 16;
  localparam int TIME_W     = 32;
  localparam int CPM_W      = 24;
  localparam int FACTOR_W   = 20;
  localparam int THRESH_W   = 24;
  localparam int DOSE_W     = 44;
  localparam int MUL_CONST_W = 16;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 72;

  localparam logic [MUL_CONST_W-1:0] MS_PER_MIN = 16'd60000;
  localparam logic [CPM_W-1:0]       CPM_MAX    = 24'hFF_FFFF;

  localparam logic [FACTOR_W-1:0] DOSE_FACTOR_RST = 20'd5977;
  localparam logic [THRESH_W-1:0] ALERT_THRESH_RST = 24'd3500;

  localparam logic [CFG_IDX_W-1:0] REG_DOSE_FACTOR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALERT_THRESHOLD = 8'd1;

endpackage

### sv/wprm_div.sv
module wprm_div #(
  parameter int DVD_W = 36
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [DVD_W-1:0]             dividend,
  input  logic [wprm_pkg::TIME_W-1:0]  divisor,
  output logic                         done,
  output logic [DVD_W-1:0]             quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);
  localparam int TW    = wprm_pkg::TIME_W;

  logic               busy;
  logic [CNT_W-1:0]   step;
  logic [DVD_W-1:0]   acc;
  logic [TW:0]        rem;
  logic [TW-1:0]      dvs;
  logic [TW:0]        rem_sh;
  logic [TW:0]        diff;
  logic               take;

  // restoring division, one quotient bit per cycle
  assign rem_sh = {rem[TW-1:0], acc[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dvs};
  assign take   = ~diff[TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy <= 1'b1;
        step <= CNT_W'(DVD_W);
      end else if (busy) begin
        step <= step - CNT_W'(1);
        if (step == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      rem <= take ? diff : rem_sh;
      acc <= {acc[DVD_W-2:0], take};
    end
  end

  assign quotient = acc;

endmodule

### sv/windowed_pulse_rate_meter_unit.sv
// Steps: read ring, update sum and slot, read oldest stamp, form span and dividend,
//   divide (DVD_W = pulse sum width + 16: 36 bits at WINDOW 16), dose, output.
// Input: one transaction at a time, taken only in the idle state; a zero span
//   skips the serial divider (one quotient bit per cycle), the longest step.
//   A finished result waits in the output register while the next item is taken.
// Reset (rst, synchronous): ring empty, write slot 0, sum 0, registers to defaults.
module windowed_pulse_rate_meter_unit #(
  parameter int WINDOW = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [15:0] pulse_count, [47:16] timestamp_ms
  input  logic [wprm_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [23:0] cpm, [67:24] dose_rate, [68] high_alert, [71:69] zero
  output logic [wprm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wprm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wprm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int SUM_W  = $clog2(WINDOW * 65535 + 1);
  localparam int DVD_W  = SUM_W + wprm_pkg::MUL_CONST_W;
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CW     = wprm_pkg::COUNT_W;
  localparam int TW     = wprm_pkg::TIME_W;
  localparam int CPMW   = wprm_pkg::CPM_W;
  localparam int DW     = wprm_pkg::DOSE_W;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_READ   = 9'b000000010,
    S_UPDATE = 9'b000000100,
    S_RDTIME = 9'b000001000,
    S_MUL    = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_WAIT   = 9'b001000000,
    S_DOSE   = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;

  logic [wprm_pkg::FACTOR_W-1:0] dose_factor;
  logic [wprm_pkg::THRESH_W-1:0] alert_threshold;

  logic [CW-1:0]     count_mem [WINDOW];
  logic [TW-1:0]     time_mem  [WINDOW];
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [SLOT_W-1:0] oldest_slot;
  logic              ring_full;
  logic [SUM_W-1:0]  pulse_sum;

  logic [CW-1:0]     in_count;
  logic [TW-1:0]     in_stamp;
  logic [CW-1:0]     old_count;
  logic [TW-1:0]     old_time;
  logic [TW-1:0]     span;
  logic [DVD_W-1:0]  dividend;
  logic [DVD_W-1:0]  quotient;
  logic [CPMW-1:0]   cpm;
  logic [DW-1:0]     dose;
  logic              alert;

  logic [CPMW-1:0]   out_cpm;
  logic [DW-1:0]     out_dose;
  logic              out_alert;

  logic              div_start;
  logic              div_done;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  assign write_slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0
                                                               : write_slot + SLOT_W'(1);
  assign oldest_slot     = ring_full ? write_slot : '0;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      dose_factor     <= wprm_pkg::DOSE_FACTOR_RST;
      alert_threshold <= wprm_pkg::ALERT_THRESH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wprm_pkg::REG_DOSE_FACTOR:
          dose_factor <= cfg_data[wprm_pkg::FACTOR_W-1:0];
        wprm_pkg::REG_ALERT_THRESHOLD:
          alert_threshold <= cfg_data[wprm_pkg::THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // ring memories; reads registered
  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      count_mem[write_slot] <= in_count;
    end
    old_count <= count_mem[write_slot];
  end

  always_ff @(posedge clk) begin
    if (state == S_UPDATE) begin
      time_mem[write_slot] <= in_stamp;
    end
    old_time <= time_mem[oldest_slot];
  end

  wprm_div #(
    .DVD_W(DVD_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span),
    .done     (div_done),
    .quotient (quotient)
  );

  assign div_start = (state == S_DIV) && (span != '0);

  // sequencer and ring control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      write_slot    <= '0;
      ring_full     <= 1'b0;
      pulse_sum     <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_OUT handles its own handshake below
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            state <= S_READ;
          end
        end
        S_READ:   state <= S_UPDATE;
        S_UPDATE: begin
          pulse_sum  <= pulse_sum - (ring_full ? SUM_W'(old_count) : '0) + SUM_W'(in_count);
          write_slot <= write_slot_next;
          if (write_slot_next == '0) begin
            ring_full <= 1'b1;
          end
          state <= S_RDTIME;
        end
        S_RDTIME: state <= S_MUL;
        S_MUL:    state <= S_DIV;
        S_DIV:    state <= (span == '0) ? S_DOSE : S_WAIT;
        S_WAIT: begin
          if (div_done) begin
            state <= S_DOSE;
          end
        end
        S_DOSE:   state <= S_OUT;
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default:  state <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_axis_tvalid) begin
      in_count <= s_axis_tdata[CW-1:0];
      in_stamp <= s_axis_tdata[CW+TW-1:CW];
    end
    if (state == S_MUL) begin
      span     <= in_stamp - old_time;
      dividend <= DVD_W'(pulse_sum) * DVD_W'(wprm_pkg::MS_PER_MIN);
    end
    if (state == S_DIV && span == '0) begin
      cpm <= '0;
    end
    if (state == S_WAIT && div_done) begin
      cpm <= (quotient[DVD_W-1:CPMW] != '0) ? wprm_pkg::CPM_MAX : quotient[CPMW-1:0];
    end
    if (state == S_DOSE) begin
      dose  <= DW'(cpm) * DW'(dose_factor);
      alert <= (cpm > alert_threshold);
    end
    if (state == S_OUT && (!m_axis_tvalid || m_axis_tready)) begin
      out_cpm   <= cpm;
      out_dose  <= dose;
      out_alert <= alert;
    end
  end

  assign m_axis_tdata = {3'b000, out_alert, out_dose, out_cpm};

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken twice in a row");

  // alert agrees with cpm and threshold on the presented result
  a_alert_consistent: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[68] == (m_axis_tdata[23:0] > alert_threshold)))
    else $error("high_alert inconsistent with cpm");

  // zero rate gives zero dose
  a_zero_dose: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[23:0] == '0) |-> (m_axis_tdata[67:24] == '0))
    else $error("nonzero dose at zero cpm");

  // once full the ring stays full
  a_full_sticky: assert property (@(posedge clk) disable iff (rst)
    ring_full |=> ring_full)
    else $error("ring_full cleared");

endmodule

### bench/testbench.sv
module testbench;

  localparam int WINDOW      = 16;
  localparam int SLOT_W      = $clog2(WINDOW);
  localparam int SUM_W       = wprm_pkg::COUNT_W + SLOT_W;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 190;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_WAIT  = 60;

  // indexes past the register list, must be ignored
  localparam logic [wprm_pkg::CFG_IDX_W-1:0] IDX_UNUSED_FIRST = 8'd2;
  localparam logic [wprm_pkg::CFG_IDX_W-1:0] IDX_UNUSED_LAST  = 8'hFF;

  typedef struct packed {
    logic [wprm_pkg::CPM_W-1:0]  cpm;
    logic [wprm_pkg::DOSE_W-1:0] dose;
    logic                        alert;
  } rate_t;

  typedef struct packed {
    logic [wprm_pkg::COUNT_W-1:0] count;
    logic [wprm_pkg::TIME_W-1:0]  stamp;
    logic                         typed;
    rate_t                        want;
  } reading_row_t;

  logic                            clk;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [wprm_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [wprm_pkg::M_TDATA_W-1:0]  m_axis_tdata;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [wprm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [wprm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  windowed_pulse_rate_meter_unit #(.WINDOW(WINDOW)) DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // window model
  logic [wprm_pkg::COUNT_W-1:0]  cnt_ring [WINDOW];
  logic [wprm_pkg::TIME_W-1:0]   stamp_ring [WINDOW];
  logic [SLOT_W-1:0]             next_slot = '0;
  logic                          ring_wrapped = 1'b0;
  logic [SUM_W-1:0]              window_sum = '0;
  logic [wprm_pkg::FACTOR_W-1:0] dose_factor_q = wprm_pkg::DOSE_FACTOR_RST;
  logic [wprm_pkg::THRESH_W-1:0] alert_level = wprm_pkg::ALERT_THRESH_RST;

  rate_t        rate_expected [$];
  reading_row_t directed_rows [$];
  logic [wprm_pkg::TIME_W-1:0] stamp_now = '0;

  int  err_count = 0;
  int  readings_sent = 0;
  int  results_seen = 0;
  int  cfg_writes = 0;
  int  saturated = 0;
  int  alerts = 0;
  bit  calm_in = 1'b0;
  bit  calm_out = 1'b0;
  int  stall_left = 0;
  int  idle_cycles = 0;
  rate_t got, want_now;

  function automatic rate_t predict_rate(input logic [wprm_pkg::COUNT_W-1:0] count,
                                         input logic [wprm_pkg::TIME_W-1:0] stamp);
    logic [SLOT_W-1:0]           slot, oldest;
    logic [wprm_pkg::TIME_W-1:0] span;
    logic [63:0]                 quot, prod;
    rate_t                       r;
    slot = next_slot;
    if (ring_wrapped) window_sum = window_sum - SUM_W'(cnt_ring[slot]);
    window_sum = window_sum + SUM_W'(count);
    cnt_ring[slot] = count;
    stamp_ring[slot] = stamp;
    if (int'(slot) == WINDOW - 1) next_slot = '0;
    else next_slot = slot + SLOT_W'(1);
    if (next_slot == '0) ring_wrapped = 1'b1;
    // oldest is the slot about to be overwritten once wrapped
    oldest = ring_wrapped ? next_slot : '0;
    span = stamp_ring[slot] - stamp_ring[oldest];
    if (span == '0) quot = 64'd0;
    else quot = ({{(64-SUM_W){1'b0}}, window_sum} * 64'(wprm_pkg::MS_PER_MIN)) /
                {32'd0, span};
    r.cpm = (quot > {40'd0, wprm_pkg::CPM_MAX}) ? wprm_pkg::CPM_MAX
                                                 : quot[wprm_pkg::CPM_W-1:0];
    prod = {40'd0, r.cpm} * {44'd0, dose_factor_q};
    r.dose = prod[wprm_pkg::DOSE_W-1:0];
    r.alert = (r.cpm > alert_level);
    return r;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 4);
    if (r < 96) return $urandom_range(5, 20);
    return $urandom_range(40, 120);
  endfunction

  function automatic reading_row_t random_reading();
    reading_row_t row;
    int mode;
    row = '0;
    mode = $urandom_range(0, 99);
    if (mode < 70) begin
      // ordinary sampling: modest counts, forward time steps
      row.count = 16'($urandom_range(0, 150));
      stamp_now = stamp_now + $urandom_range(1, 3000);
    end else if (mode < 78) begin
      // heavy counts over a few ms: pushes cpm into saturation
      row.count = 16'($urandom_range(0, 16'hFFFF));
      stamp_now = stamp_now + $urandom_range(1, 5);
    end else if (mode < 84) begin
      row.count = 16'($urandom_range(0, 300));
    end else if (mode < 90) begin
      // jump anywhere, often backwards
      row.count = 16'($urandom_range(0, 16'hFFFF));
      stamp_now = $urandom;
    end else begin
      row.count = 16'($urandom_range(0, 16'hFFFF));
      stamp_now = stamp_now + $urandom_range(0, 100000);
    end
    row.stamp = stamp_now;
    return row;
  endfunction

  task automatic add_row(input logic [wprm_pkg::COUNT_W-1:0] count,
                         input logic [wprm_pkg::TIME_W-1:0] stamp,
                         input logic typed, input logic [wprm_pkg::CPM_W-1:0] cpm,
                         input logic [wprm_pkg::DOSE_W-1:0] dose, input logic alert);
    reading_row_t row;
    row.count = count;
    row.stamp = stamp;
    row.typed = typed;
    row.want.cpm = cpm;
    row.want.dose = dose;
    row.want.alert = alert;
    directed_rows.push_back(row);
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic send_reading(input reading_row_t row);
    int gap;
    rate_t want;
    if ($urandom_range(0, 99) < 3) calm_in = !calm_in;
    gap = calm_in ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tdata <= {row.stamp, row.count};
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    want = predict_rate(row.count, row.stamp);
    if (row.typed) want = row.want;
    rate_expected.push_back(want);
    readings_sent++;
    @(negedge clk);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic set_register(input logic [wprm_pkg::CFG_IDX_W-1:0] idx,
                              input logic [wprm_pkg::CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == wprm_pkg::REG_DOSE_FACTOR)
      dose_factor_q = value[wprm_pkg::FACTOR_W-1:0];
    else if (idx == wprm_pkg::REG_ALERT_THRESHOLD)
      alert_level = value[wprm_pkg::THRESH_W-1:0];
    cfg_writes++;
    @(negedge clk);
  endtask

  task automatic wait_results();
    while (rate_expected.size() != 0) @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got_v,
                                 input logic [63:0] want_v);
    $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d)",
             what, got_v, want_v, results_seen);
    err_count++;
  endtask

  // receiver with random back-pressure
  always @(negedge clk) begin
    if ($urandom_range(0, 99) < 1) calm_out = !calm_out;
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!calm_out && $urandom_range(0, 99) < 20) begin
      stall_left = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.cpm = m_axis_tdata[23:0];
      got.dose = m_axis_tdata[67:24];
      got.alert = m_axis_tdata[68];
      results_seen++;
      if (got.cpm == wprm_pkg::CPM_MAX) saturated++;
      if (got.alert) alerts++;
      if (rate_expected.size() == 0) begin
        report_mismatch("result with nothing pending", 64'(got.cpm), 64'd0);
      end else begin
        want_now = rate_expected.pop_front();
        if (got.cpm != want_now.cpm)
          report_mismatch("cpm", 64'(got.cpm), 64'(want_now.cpm));
        if (got.dose != want_now.dose)
          report_mismatch("dose_rate", 64'(got.dose), 64'(want_now.dose));
        if (got.alert != want_now.alert)
          report_mismatch("high_alert", 64'(got.alert), 64'(want_now.alert));
      end
    end
  end

  // watchdog: any transaction on any channel counts as progress
  initial begin
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    //       count     stamp          typed cpm               dose              alert
    add_row(16'h0000, 32'h0000_0000, 1'b1, 24'd0,            44'd0,            1'b0);
    add_row(16'd35,   32'd600,       1'b1, 24'd3500,         44'd20919500,     1'b0);
    add_row(16'h0000, 32'd599,       1'b1, 24'd3505,         44'd20949385,     1'b1);
    add_row(16'hFFFF, 32'h0000_0000, 1'b1, 24'd0,            44'd0,            1'b0);
    add_row(16'hFFFF, 32'h0000_0001, 1'b1, wprm_pkg::CPM_MAX, 44'd100277414055, 1'b1);
    add_row(16'h0000, 32'hFFFF_FFFF, 1'b1, 24'd1,            44'd5977,         1'b0);
    add_row(16'hFFFF, 32'h8000_0000, 1'b0, '0, '0, 1'b0);
    add_row(16'hAAAA, 32'h8000_1000, 1'b0, '0, '0, 1'b0);
    add_row(16'h5555, 32'h8000_2000, 1'b0, '0, '0, 1'b0);
    add_row(16'hFFFF, 32'h8000_3000, 1'b0, '0, '0, 1'b0);
    add_row(16'h8000, 32'h8000_4000, 1'b0, '0, '0, 1'b0);
    add_row(16'h0001, 32'h8000_5000, 1'b0, '0, '0, 1'b0);
    add_row(16'hFFFF, 32'h8000_6000, 1'b0, '0, '0, 1'b0);
    add_row(16'h7FFF, 32'h8000_7000, 1'b0, '0, '0, 1'b0);
    add_row(16'hFFFF, 32'h8000_8000, 1'b0, '0, '0, 1'b0);
    add_row(16'hFFFF, 32'h8000_9000, 1'b0, '0, '0, 1'b0);
    // ring now full: oldest moves with the write slot
    add_row(16'hFFFF, 32'h8000_B000, 1'b0, '0, '0, 1'b0);
    add_row(16'h0000, 32'h8000_B000, 1'b0, '0, '0, 1'b0);
    add_row(16'h1234, 32'h0000_0010, 1'b0, '0, '0, 1'b0);
    add_row(16'hFFFF, 32'h7FFF_FFFF, 1'b0, '0, '0, 1'b0);
    add_row(16'h00FF, 32'h8001_0000, 1'b0, '0, '0, 1'b0);
    add_row(16'h0000, 32'hFFFF_0000, 1'b0, '0, '0, 1'b0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) send_reading(directed_rows[i]);
    s_axis_tvalid <= 1'b0;
    stamp_now = 32'hFFFF_0000;

    for (int phase = 0; phase < PHASES; phase++) begin
      wait_results();
      case (phase)
        0: begin
          set_register(wprm_pkg::REG_DOSE_FACTOR, '0);
          set_register(wprm_pkg::REG_ALERT_THRESHOLD, '0);
        end
        1: begin
          // upper data bits beyond the dose factor width are dropped
          set_register(wprm_pkg::REG_DOSE_FACTOR, 24'hFF_FFFF);
          set_register(wprm_pkg::REG_ALERT_THRESHOLD, 24'hFF_FFFF);
        end
        2: begin
          set_register(IDX_UNUSED_FIRST, 24'($urandom_range(0, 24'hFF_FFFF)));
          set_register(IDX_UNUSED_LAST, 24'($urandom_range(0, 24'hFF_FFFF)));
          set_register(wprm_pkg::REG_DOSE_FACTOR, 24'($urandom_range(0, 20'hF_FFFF)));
          set_register(wprm_pkg::REG_ALERT_THRESHOLD, 24'($urandom_range(0, 8000)));
        end
        5: begin
          set_register(wprm_pkg::REG_DOSE_FACTOR, 24'd1);
          set_register(wprm_pkg::REG_ALERT_THRESHOLD, 24'd1);
        end
        default: begin
          set_register(wprm_pkg::REG_DOSE_FACTOR, 24'($urandom_range(0, 20'hF_FFFF)));
          set_register(wprm_pkg::REG_ALERT_THRESHOLD, 24'($urandom_range(0, 8000)));
        end
      endcase
      cfg_valid <= 1'b0;
      repeat (PHASE_ITEMS) send_reading(random_reading());
      s_axis_tvalid <= 1'b0;
    end

    wait_results();
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("%0d readings sent, %0d results checked, %0d register writes",
             readings_sent, results_seen, cfg_writes);
    $display("cpm saturated in %0d results, alert raised in %0d", saturated, alerts);
    if (err_count == 0 && rate_expected.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
